FILE: sv/pickup_difference_over_sum_averager_assert.svh
// Assertion macros shared by the pickup difference-over-sum averager.
// Depends on nothing; included by the top level.
`ifndef PICKUP_DIFFERENCE_OVER_SUM_AVERAGER_ASSERT_SVH
`define PICKUP_DIFFERENCE_OVER_SUM_AVERAGER_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define PDSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Antecedent implies the consequent in the same cycle.
`define PDSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that holds in the cycle after reset is seen.
`define PDSA_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("post-reset check failed");

`endif

FILE: sv/pdsa_pkg.sv
// Package for the pickup difference-over-sum averager: sizes, state type
// and the command/status structs between controller and datapath. No dependencies.
package pdsa_pkg;

   localparam int WINDOW      = 16;
   localparam int SAMPLE_BITS = 16;  // at most the 16-bit port width
   localparam int CHANNELS    = 6;

   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
   localparam int DIFF_W    = SUM_W + 1;
   localparam int ND_W      = SUM_W + 3;
   localparam int REM_W     = ND_W + 1;
   localparam int Q_BITS    = 16;
   localparam int FRAC_BITS = 14;
   localparam int QINT_BITS = Q_BITS - FRAC_BITS;
   localparam int CNT_W     = $clog2(Q_BITS);
   localparam int SCALE_W   = 31;
   localparam int RES_W     = 32;
   localparam int PROD_W    = Q_BITS + SCALE_W + 1;
   localparam int SH_W      = PROD_W - FRAC_BITS;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIFF,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic diff;
      logic prep;
      logic div_step;
      logic mul;
      logic scale;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic shot_ok;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

FILE: sv/pickup_difference_over_sum_averager.sv
// Top level of the pickup difference-over-sum averager.
// Instantiates pdsa_ctrl and pdsa_datapath; uses pdsa_pkg and the assertion header.
//
// Usage:
//   The req channel carries one beat per beam shot: four pickup samples and
//   two reference samples, signed 16 bits. The rsp channel returns one beat
//   per shot: the Q16.16 scaled difference-over-sum value and a flag that is
//   set when the ratio was computed for this shot. When a window difference
//   or the denominator is zero, the flag is clear and the last good value is
//   repeated. The csr port writes the 31-bit Q15.16 scale factor; write it
//   only while no shot is in flight.
//   A shot that computes a ratio passes through the update, diff and prep
//   states, the sixteen iterations of the serial restoring divider, and the
//   mul, scale and done states; a degenerate shot goes from prep to done.
//   One shot is worked at a time, so a new beat is taken only after the
//   previous result has been handed to the output register.
//   Reset clears the window (through per-entry valid bits), the running sums,
//   the held value and the write slot, and loads the scale factor with 1.0.
//   If the receiver stalls, the result waits in the output register; the next
//   shot is accepted and computed meanwhile, and only its handoff waits.
`include "pickup_difference_over_sum_averager_assert.svh"

module pickup_difference_over_sum_averager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [15:0]                 req_pickup_one,
   input  logic signed [15:0]                 req_pickup_two,
   input  logic signed [15:0]                 req_reference_one,
   input  logic signed [15:0]                 req_pickup_three,
   input  logic signed [15:0]                 req_pickup_four,
   input  logic signed [15:0]                 req_reference_two,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pdsa_pkg::RES_W-1:0]  rsp_resolution_value,
   output logic                               rsp_ratio_valid,
   input  logic                               csr_wr_en,
   input  logic [pdsa_pkg::SCALE_W-1:0]       csr_wr_data
);

   pdsa_pkg::cmd_type    cmd;
   pdsa_pkg::status_type status;

   // The controller only sequences; all arithmetic and storage is in the datapath.
   pdsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdsa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pickup_one       (req_pickup_one),
      .req_pickup_two       (req_pickup_two),
      .req_reference_one    (req_reference_one),
      .req_pickup_three     (req_pickup_three),
      .req_pickup_four      (req_pickup_four),
      .req_reference_two    (req_reference_two),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_resolution_value (rsp_resolution_value),
      .rsp_ratio_valid      (rsp_ratio_valid)
   );

   // A shot that was just accepted keeps the input closed for its work.
   `PDSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // The output register is loaded only when its previous beat is gone.
   `PDSA_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_out, status.out_free)
   // Reset leaves no result pending and the input open.
   `PDSA_ASSERT_AFTER_RESET(a_reset_state, clock, reset, !rsp_valid && req_ready)

endmodule

FILE: sv/pdsa_datapath.sv
// Datapath of the pickup difference-over-sum averager: window memory, running
// sums, differences, serial divider, scaling multiplier and output register. Uses pdsa_pkg.
module pdsa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pdsa_pkg::cmd_type             cmd,
   output pdsa_pkg::status_type          status,
   input  logic signed [15:0]            req_pickup_one,
   input  logic signed [15:0]            req_pickup_two,
   input  logic signed [15:0]            req_reference_one,
   input  logic signed [15:0]            req_pickup_three,
   input  logic signed [15:0]            req_pickup_four,
   input  logic signed [15:0]            req_reference_two,
   input  logic                          csr_wr_en,
   input  logic [pdsa_pkg::SCALE_W-1:0]  csr_wr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [pdsa_pkg::RES_W-1:0] rsp_resolution_value,
   output logic                          rsp_ratio_valid
);

   localparam int SB  = pdsa_pkg::SAMPLE_BITS;
   localparam int CH  = pdsa_pkg::CHANNELS;
   localparam int ROW = CH * SB;

   // Captured shot, channel order pu1, pu2, ref1, pu3, pu4, ref2.
   logic signed [SB-1:0] req_sample [CH];
   logic signed [SB-1:0] sample_ff [CH];

   // Window memory; entries not yet written read as zero through valid bits.
   logic [ROW-1:0]                  hist_mem [pdsa_pkg::WINDOW];
   logic [pdsa_pkg::WINDOW-1:0]     entry_valid_ff;
   logic [ROW-1:0]                  rd_data_ff;
   logic                            rd_valid_ff;
   logic [pdsa_pkg::SLOT_W-1:0]     slot_ff;
   logic [ROW-1:0]                  wr_row;

   logic signed [pdsa_pkg::SUM_W-1:0] sums_ff [CH];

   logic signed [pdsa_pkg::DIFF_W-1:0] d11, d12, d21, d22;
   logic signed [pdsa_pkg::DIFF_W:0]   pair1, pair2;
   logic signed [pdsa_pkg::ND_W-1:0]   num_c, den_c, num_ff, den_ff;
   logic                               shot_ok_ff;

   logic [pdsa_pkg::ND_W-1:0]    mag_n, mag_d, mag_d_ff;
   logic [pdsa_pkg::REM_W-1:0]   rem_ff, rem_try;
   logic [pdsa_pkg::Q_BITS-1:0]  dvd_ff, quo_ff;
   logic [pdsa_pkg::CNT_W-1:0]   cnt_ff;
   logic                         neg_ff, sat_ff, rem_ge;

   logic [pdsa_pkg::SCALE_W-1:0]       scale_ff;
   logic signed [pdsa_pkg::Q_BITS-1:0] q_val;
   logic signed [pdsa_pkg::SCALE_W:0]  scale_s;
   logic signed [pdsa_pkg::PROD_W-1:0] prod_c, prod_ff, prod_adj;
   logic signed [pdsa_pkg::SH_W-1:0]   shifted;
   logic signed [pdsa_pkg::RES_W-1:0]  res_sat, last_res_ff;
   logic                               fits;

   logic                               rsp_valid_ff, out_ok_ff;
   logic signed [pdsa_pkg::RES_W-1:0]  out_value_ff;

   always_comb begin
      req_sample[0] = req_pickup_one[SB-1:0];
      req_sample[1] = req_pickup_two[SB-1:0];
      req_sample[2] = req_reference_one[SB-1:0];
      req_sample[3] = req_pickup_three[SB-1:0];
      req_sample[4] = req_pickup_four[SB-1:0];
      req_sample[5] = req_reference_two[SB-1:0];
      for (int c = 0; c < CH; c++) begin
         wr_row[c*SB +: SB] = sample_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int c = 0; c < CH; c++) begin
            sample_ff[c] <= req_sample[c];
         end
         rd_data_ff  <= hist_mem[slot_ff];
         rd_valid_ff <= entry_valid_ff[slot_ff];
      end
      if (cmd.update) begin
         hist_mem[slot_ff] <= wr_row;
      end
   end

   // Window bookkeeping and running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         slot_ff        <= '0;
         for (int c = 0; c < CH; c++) begin
            sums_ff[c] <= '0;
         end
      end else if (cmd.update) begin
         entry_valid_ff[slot_ff] <= 1'b1;
         if (slot_ff == pdsa_pkg::SLOT_W'(pdsa_pkg::WINDOW - 1)) begin
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
         for (int c = 0; c < CH; c++) begin
            sums_ff[c] <= sums_ff[c]
                        - (rd_valid_ff ? pdsa_pkg::SUM_W'($signed(rd_data_ff[c*SB +: SB]))
                                       : '0)
                        + pdsa_pkg::SUM_W'(sample_ff[c]);
         end
      end
   end

   always_comb begin
      d11   = pdsa_pkg::DIFF_W'(sums_ff[0]) - pdsa_pkg::DIFF_W'(sums_ff[2]);
      d12   = pdsa_pkg::DIFF_W'(sums_ff[1]) - pdsa_pkg::DIFF_W'(sums_ff[2]);
      d21   = pdsa_pkg::DIFF_W'(sums_ff[3]) - pdsa_pkg::DIFF_W'(sums_ff[5]);
      d22   = pdsa_pkg::DIFF_W'(sums_ff[4]) - pdsa_pkg::DIFF_W'(sums_ff[5]);
      pair1 = (pdsa_pkg::DIFF_W+1)'(d11) + (pdsa_pkg::DIFF_W+1)'(d12);
      pair2 = (pdsa_pkg::DIFF_W+1)'(d21) + (pdsa_pkg::DIFF_W+1)'(d22);
      num_c = pdsa_pkg::ND_W'(pair1) - pdsa_pkg::ND_W'(pair2);
      den_c = pdsa_pkg::ND_W'(pair1) + pdsa_pkg::ND_W'(pair2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shot_ok_ff <= 1'b0;
      end else if (cmd.diff) begin
         shot_ok_ff <= (d11 != 0) && (d12 != 0) && (d21 != 0) && (d22 != 0)
                       && (den_c != 0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         num_ff <= num_c;
         den_ff <= den_c;
      end
   end

   // Restoring divider on magnitudes, one quotient bit per cycle.
   always_comb begin
      mag_n   = num_ff[pdsa_pkg::ND_W-1] ? -num_ff : num_ff;
      mag_d   = den_ff[pdsa_pkg::ND_W-1] ? -den_ff : den_ff;
      rem_try = {rem_ff[pdsa_pkg::REM_W-2:0], dvd_ff[pdsa_pkg::Q_BITS-1]};
      rem_ge  = rem_try >= {1'b0, mag_d_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         mag_d_ff <= mag_d;
         neg_ff   <= num_ff[pdsa_pkg::ND_W-1] ^ den_ff[pdsa_pkg::ND_W-1];
         // Quotient would need more than Q_BITS bits: saturate; the division result is then ignored.
         sat_ff   <= {2'b00, mag_n} >= {mag_d, 2'b00};
         rem_ff   <= pdsa_pkg::REM_W'(mag_n >> pdsa_pkg::QINT_BITS);
         dvd_ff   <= {mag_n[pdsa_pkg::QINT_BITS-1:0], {pdsa_pkg::FRAC_BITS{1'b0}}};
         quo_ff   <= '0;
         cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_try - {1'b0, mag_d_ff} : rem_try;
         dvd_ff <= dvd_ff << 1;
         quo_ff <= {quo_ff[pdsa_pkg::Q_BITS-2:0], rem_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Signed, saturated Q2.14 ratio and the scale product.
   always_comb begin
      if (!neg_ff) begin
         if (sat_ff || quo_ff[pdsa_pkg::Q_BITS-1]) begin
            q_val = {1'b0, {(pdsa_pkg::Q_BITS-1){1'b1}}};
         end else begin
            q_val = quo_ff;
         end
      end else begin
         if (sat_ff || (quo_ff[pdsa_pkg::Q_BITS-1] && (quo_ff[pdsa_pkg::Q_BITS-2:0] != 0))) begin
            q_val = {1'b1, {(pdsa_pkg::Q_BITS-1){1'b0}}};
         end else begin
            q_val = -quo_ff;
         end
      end
      scale_s = {1'b0, scale_ff};
      prod_c  = pdsa_pkg::PROD_W'(q_val) * pdsa_pkg::PROD_W'(scale_s);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_c;
      end
   end

   // Divide by 2^14 toward zero, then clamp to 32 bits.
   always_comb begin
      prod_adj = prod_ff + (prod_ff[pdsa_pkg::PROD_W-1]
                            ? pdsa_pkg::PROD_W'((1 << pdsa_pkg::FRAC_BITS) - 1)
                            : pdsa_pkg::PROD_W'(0));
      shifted  = prod_adj[pdsa_pkg::PROD_W-1:pdsa_pkg::FRAC_BITS];
      fits     = (shifted[pdsa_pkg::SH_W-1:pdsa_pkg::RES_W-1] == '0)
                 || (shifted[pdsa_pkg::SH_W-1:pdsa_pkg::RES_W-1] == '1);
      if (fits) begin
         res_sat = shifted[pdsa_pkg::RES_W-1:0];
      end else if (shifted[pdsa_pkg::SH_W-1]) begin
         res_sat = {1'b1, {(pdsa_pkg::RES_W-1){1'b0}}};
      end else begin
         res_sat = {1'b0, {(pdsa_pkg::RES_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_res_ff <= '0;
         scale_ff    <= pdsa_pkg::SCALE_RESET;
      end else begin
         if (cmd.scale) begin
            last_res_ff <= res_sat;
         end
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
      end
   end

   // Output register decouples the result from the next shot's work.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff <= last_res_ff;
         out_ok_ff    <= shot_ok_ff;
      end
   end

   assign status.shot_ok  = shot_ok_ff;
   assign status.div_last = (cnt_ff == pdsa_pkg::CNT_W'(pdsa_pkg::Q_BITS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_resolution_value = out_value_ff;
   assign rsp_ratio_valid      = out_ok_ff;

endmodule

FILE: sv/pdsa_ctrl.sv
// Controller of the pickup difference-over-sum averager: sequences one shot
// through the datapath. Uses pdsa_pkg.
module pdsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pdsa_pkg::status_type status,
   output pdsa_pkg::cmd_type    cmd
);

   pdsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pdsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pdsa_pkg::ST_UPDATE;
            end
         end
         pdsa_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = pdsa_pkg::ST_DIFF;
         end
         pdsa_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = pdsa_pkg::ST_PREP;
         end
         pdsa_pkg::ST_PREP: begin
            // A degenerate shot skips the arithmetic and repeats the held value.
            if (status.shot_ok) begin
               cmd.prep = 1'b1;
               state_in = pdsa_pkg::ST_DIV;
            end else begin
               state_in = pdsa_pkg::ST_DONE;
            end
         end
         pdsa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = pdsa_pkg::ST_MUL;
            end
         end
         pdsa_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pdsa_pkg::ST_SCALE;
         end
         pdsa_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = pdsa_pkg::ST_DONE;
         end
         pdsa_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = pdsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdsa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
